FILE: src/bsrf_pkg.sv
// shared types and constants for the bind state redundancy filter
// no dependencies
`timescale 1ns / 1ps

package bsrf_pkg;

    localparam int TRACKED_UNITS = 32;
    localparam int UNIT_IDX_W    = (TRACKED_UNITS > 1) ? $clog2(TRACKED_UNITS) : 1;

    localparam logic [7:0]  TRACKED_LIMIT     = 8'(TRACKED_UNITS);
    localparam logic [15:0] TARGET_TEXTURE_2D = 16'd3553;

    typedef enum logic [2:0] {
        OP_BIND_SHADER  = 3'd0,
        OP_BIND_TEXTURE = 3'd1,
        OP_INV_SHADER   = 3'd2,
        OP_INV_TEXTURE  = 3'd3,
        OP_RESET        = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_USE_PROGRAM  = 2'd0,
        KIND_SELECT_UNIT  = 2'd1,
        KIND_BIND_TEXTURE = 2'd2
    } t_kind;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit_second;
    } t_dp_cmd;

    typedef struct packed {
        logic two_words;
    } t_dp_status;

endpackage

FILE: src/bsrf_ctrl.sv
// controller state machine for the bind state redundancy filter
// depends on bsrf_pkg
`timescale 1ns / 1ps

module bsrf_ctrl
    import bsrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SECOND
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_state <= i_status.two_words ? ST_SECOND : ST_IDLE;
                end
                ST_SECOND: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_cmd.load        = start && (r_state == ST_IDLE);
    assign o_cmd.exec        = (r_state == ST_EVAL);
    assign o_cmd.emit_second = (r_state == ST_SECOND);

endmodule

FILE: src/bsrf_dp.sv
// datapath: tracked program, active unit, per-unit table and output word register
// depends on bsrf_pkg
`timescale 1ns / 1ps

module bsrf_dp
    import bsrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_program_id,
    input  logic [15:0] i_bind_target,
    input  logic [31:0] i_texture_id,
    input  logic [7:0]  i_unit_index,
    output logic        o_strobe,
    output logic [1:0]  o_command_kind,
    output logic [31:0] o_command_value,
    output logic [15:0] o_command_target,
    output logic        o_last
);

    logic [2:0]  r_op;
    logic [31:0] r_prog;
    logic [15:0] r_tgt;
    logic [31:0] r_tex;
    logic [7:0]  r_unit;

    logic [31:0]           r_bound_prog;
    logic                  r_act_known;
    logic [UNIT_IDX_W-1:0] r_act_idx;
    logic [15:0]           r_utgt [TRACKED_UNITS];
    logic [31:0]           r_utex [TRACKED_UNITS];

    logic                  r_strobe;
    logic [1:0]            r_kind;
    logic [31:0]           r_value;
    logic [15:0]           r_target;
    logic                  r_last;

    logic [UNIT_IDX_W-1:0] u_idx;
    logic                  untracked;
    logic                  entry_diff;
    logic                  act_match;

    assign u_idx      = r_unit[UNIT_IDX_W-1:0];
    assign untracked  = (r_unit >= TRACKED_LIMIT);
    assign entry_diff = (r_utex[u_idx] != r_tex) || (r_utgt[u_idx] != r_tgt);
    assign act_match  = r_act_known && (r_act_idx == u_idx);

    assign o_status.two_words = (r_op == OP_BIND_TEXTURE) &&
                                (untracked || (entry_diff && !act_match));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_prog <= i_program_id;
            r_tgt  <= i_bind_target;
            r_tex  <= i_texture_id;
            r_unit <= i_unit_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= 1'b0;
            r_bound_prog <= '0;
            r_act_known  <= 1'b0;
            r_act_idx    <= '0;
            for (int i = 0; i < TRACKED_UNITS; i++) begin
                r_utgt[i] <= TARGET_TEXTURE_2D;
                r_utex[i] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.exec) begin
                case (r_op)
                    OP_BIND_SHADER: begin
                        if ((r_prog == '0) || (r_bound_prog != r_prog)) begin
                            r_strobe     <= 1'b1;
                            r_kind       <= KIND_USE_PROGRAM;
                            r_value      <= r_prog;
                            r_target     <= '0;
                            r_last       <= 1'b1;
                            r_bound_prog <= r_prog;
                        end
                    end
                    OP_BIND_TEXTURE: begin
                        if (untracked) begin
                            r_strobe    <= 1'b1;
                            r_kind      <= KIND_SELECT_UNIT;
                            r_value     <= {24'd0, r_unit};
                            r_target    <= '0;
                            r_last      <= 1'b0;
                            r_act_known <= 1'b0;
                        end else if (entry_diff) begin
                            r_strobe      <= 1'b1;
                            r_utgt[u_idx] <= r_tgt;
                            r_utex[u_idx] <= r_tex;
                            if (!act_match) begin
                                r_kind      <= KIND_SELECT_UNIT;
                                r_value     <= {24'd0, r_unit};
                                r_target    <= '0;
                                r_last      <= 1'b0;
                                r_act_known <= 1'b1;
                                r_act_idx   <= u_idx;
                            end else begin
                                r_kind   <= KIND_BIND_TEXTURE;
                                r_value  <= r_tex;
                                r_target <= r_tgt;
                                r_last   <= 1'b1;
                            end
                        end
                    end
                    OP_INV_SHADER: begin
                        if ((r_prog != '0) && (r_bound_prog == r_prog)) begin
                            r_bound_prog <= '0;
                        end
                    end
                    OP_INV_TEXTURE: begin
                        if (r_tex != '0) begin
                            for (int i = 0; i < TRACKED_UNITS; i++) begin
                                if (r_utex[i] == r_tex) begin
                                    r_utex[i] <= '0;
                                    r_utgt[i] <= TARGET_TEXTURE_2D;
                                end
                            end
                        end
                    end
                    OP_RESET: begin
                        r_bound_prog <= '0;
                        r_act_known  <= 1'b0;
                        for (int i = 0; i < TRACKED_UNITS; i++) begin
                            r_utgt[i] <= TARGET_TEXTURE_2D;
                            r_utex[i] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit_second) begin
                r_strobe <= 1'b1;
                r_kind   <= KIND_BIND_TEXTURE;
                r_value  <= r_tex;
                r_target <= r_tgt;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_strobe         = r_strobe;
    assign o_command_kind   = r_kind;
    assign o_command_value  = r_value;
    assign o_command_target = r_target;
    assign o_last           = r_last;

endmodule

FILE: src/bind_state_redundancy_filter.sv
// top level of the bind state redundancy filter
// depends on bsrf_pkg, bsrf_ctrl and bsrf_dp
`timescale 1ns / 1ps

// usage
//   a request word is taken at a rising edge with start high and busy low:
//   opcode, program id, bind target, texture id and unit index
//   each downstream command word shows on the o_command_* ports for exactly
//   one cycle with o_strobe high; o_last marks the final word of a request
//   redundant binds, invalidates and reset produce no word at all
// timing
//   the request is registered at the accepting edge and held in the
//   evaluate state, from which the first word is registered; the second
//   word (when there is one) follows in the next cycle from the second state
//   busy is high in the evaluate state and, for a request with two words,
//   in the second state too, so no new request is taken before the last is
//   through; the evaluate step does one table read, write and the parallel
//   invalidate match across all tracked units
// reset
//   i_rst_n low at a rising edge returns the program to 0, the active unit to
//   unknown and every table entry to texture 2d / texture 0; the reset
//   opcode does the same in its evaluate cycle
// the receiver cannot stall: every strobed word is taken in its cycle
module bind_state_redundancy_filter
    import bsrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_program_id,
    input  logic [15:0] i_bind_target,
    input  logic [31:0] i_texture_id,
    input  logic [7:0]  i_unit_index,
    output logic        o_strobe,
    output logic [1:0]  o_command_kind,
    output logic [31:0] o_command_value,
    output logic [15:0] o_command_target,
    output logic        o_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    bsrf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    bsrf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_opcode         (i_opcode),
        .i_program_id     (i_program_id),
        .i_bind_target    (i_bind_target),
        .i_texture_id     (i_texture_id),
        .i_unit_index     (i_unit_index),
        .o_strobe         (o_strobe),
        .o_command_kind   (o_command_kind),
        .o_command_value  (o_command_value),
        .o_command_target (o_command_target),
        .o_last           (o_last)
    );

endmodule

FILE: tb/tb_bind_state_redundancy_filter.sv
// self-checking testbench for bind_state_redundancy_filter
// drives request words through the start/busy port, predicts the downstream command words
// and checks each strobed word; depends on bsrf_pkg and the filter top level
`timescale 1ns / 1ps

module tb_bind_state_redundancy_filter;
    import bsrf_pkg::*;

    localparam logic [8:0] UNIT_UNKNOWN   = '1;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int         DRAIN_LIMIT    = 200;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] program_id;
        logic [15:0] bind_target;
        logic [31:0] texture_id;
        logic [7:0]  unit_index;
    } t_request;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic [15:0] target;
        logic        last;
    } t_command;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [2:0]  i_opcode      = '0;
    logic [31:0] i_program_id  = '0;
    logic [15:0] i_bind_target = '0;
    logic [31:0] i_texture_id  = '0;
    logic [7:0]  i_unit_index  = '0;
    logic        busy;
    logic        o_strobe;
    logic [1:0]  o_command_kind;
    logic [31:0] o_command_value;
    logic [15:0] o_command_target;
    logic        o_last;

    // tracked state of the filter as predicted
    logic [31:0] shadow_program;
    logic [8:0]  shadow_active_unit;
    logic [15:0] shadow_unit_target [TRACKED_UNITS];
    logic [31:0] shadow_unit_texture [TRACKED_UNITS];

    t_command expected_words[$];

    int mismatch_count = 0;
    int requests_sent  = 0;
    int spare_sent     = 0;
    int words_checked  = 0;

    bind_state_redundancy_filter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_program_id     (i_program_id),
        .i_bind_target    (i_bind_target),
        .i_texture_id     (i_texture_id),
        .i_unit_index     (i_unit_index),
        .o_strobe         (o_strobe),
        .o_command_kind   (o_command_kind),
        .o_command_value  (o_command_value),
        .o_command_target (o_command_target),
        .o_last           (o_last)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void clear_shadow_state();
        shadow_program     = '0;
        shadow_active_unit = UNIT_UNKNOWN;
        for (int i = 0; i < TRACKED_UNITS; i++) begin
            shadow_unit_target[i]  = TARGET_TEXTURE_2D;
            shadow_unit_texture[i] = '0;
        end
    endfunction

    function automatic void queue_command(input t_kind kind, input logic [31:0] value,
                                          input logic [15:0] target, input logic last);
        t_command cmd;
        cmd.kind   = kind;
        cmd.value  = value;
        cmd.target = target;
        cmd.last   = last;
        expected_words.push_back(cmd);
    endfunction

    // updates the shadow state and queues the command words a request causes
    function automatic void predict_commands(input t_request req);
        logic [4:0] slot;
        slot = req.unit_index[4:0];
        case (req.opcode)
            OP_BIND_SHADER: begin
                if (req.program_id == '0 || shadow_program != req.program_id) begin
                    queue_command(KIND_USE_PROGRAM, req.program_id, '0, 1'b1);
                    shadow_program = req.program_id;
                end
            end
            OP_BIND_TEXTURE: begin
                if (req.unit_index >= TRACKED_LIMIT) begin
                    queue_command(KIND_SELECT_UNIT, 32'(req.unit_index), '0, 1'b0);
                    queue_command(KIND_BIND_TEXTURE, req.texture_id, req.bind_target, 1'b1);
                    shadow_active_unit = UNIT_UNKNOWN;
                end else if (shadow_unit_texture[slot] != req.texture_id
                             || shadow_unit_target[slot] != req.bind_target) begin
                    if (shadow_active_unit != {1'b0, req.unit_index}) begin
                        queue_command(KIND_SELECT_UNIT, 32'(req.unit_index), '0, 1'b0);
                        shadow_active_unit = {1'b0, req.unit_index};
                    end
                    queue_command(KIND_BIND_TEXTURE, req.texture_id, req.bind_target, 1'b1);
                    shadow_unit_target[slot]  = req.bind_target;
                    shadow_unit_texture[slot] = req.texture_id;
                end
            end
            OP_INV_SHADER: begin
                if (req.program_id != '0 && shadow_program == req.program_id)
                    shadow_program = '0;
            end
            OP_INV_TEXTURE: begin
                if (req.texture_id != '0) begin
                    for (int i = 0; i < TRACKED_UNITS; i++) begin
                        if (shadow_unit_texture[i] == req.texture_id) begin
                            shadow_unit_texture[i] = '0;
                            shadow_unit_target[i]  = TARGET_TEXTURE_2D;
                        end
                    end
                end
            end
            OP_RESET: clear_shadow_state();
            default: ;
        endcase
    endfunction

    function automatic t_request make_request(input logic [2:0] opcode,
                                              input logic [31:0] program_id,
                                              input logic [15:0] bind_target,
                                              input logic [31:0] texture_id,
                                              input logic [7:0] unit_index);
        t_request req;
        req.opcode      = opcode;
        req.program_id  = program_id;
        req.bind_target = bind_target;
        req.texture_id  = texture_id;
        req.unit_index  = unit_index;
        return req;
    endfunction

    // small handle and unit pools so that redundant binds and matches are common
    function automatic t_request random_request();
        t_request req;
        int       pick;
        req.program_id  = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 7)) : $urandom();
        req.texture_id  = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 6)) : $urandom();
        req.bind_target = 16'($urandom());
        case ($urandom_range(0, 5))
            0, 1: req.bind_target = TARGET_TEXTURE_2D;
            2:    req.bind_target = 16'h8513;
            3:    req.bind_target = 16'h0DE0;
            4:    req.bind_target = 16'hFFFF;
            default: ;
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 7)
            req.unit_index = 8'($urandom_range(0, 7));
        else if (pick < 9)
            req.unit_index = 8'($urandom_range(0, TRACKED_UNITS - 1));
        else
            req.unit_index = 8'($urandom_range(TRACKED_UNITS, 255));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            req.opcode = OP_BIND_SHADER;
        else if (pick < 72)
            req.opcode = OP_BIND_TEXTURE;
        else if (pick < 80)
            req.opcode = OP_INV_SHADER;
        else if (pick < 92)
            req.opcode = OP_INV_TEXTURE;
        else if (pick < 95)
            req.opcode = OP_RESET;
        else
            req.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        return req;
    endfunction

    // leaves start high; the next call or an idle burst decides what follows
    task automatic send_request(input t_request req);
        start         <= 1'b1;
        i_opcode      <= req.opcode;
        i_program_id  <= req.program_id;
        i_bind_target <= req.bind_target;
        i_texture_id  <= req.texture_id;
        i_unit_index  <= req.unit_index;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_commands(req);
        requests_sent++;
        if (req.opcode > OP_RESET)
            spare_sent++;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_shader_binds();
        send_request(make_request(OP_BIND_SHADER, 32'h0, '0, '0, '0));
        send_request(make_request(OP_BIND_SHADER, 32'h0, '0, '0, '0));
        send_request(make_request(OP_BIND_SHADER, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(OP_BIND_SHADER, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(OP_INV_SHADER, 32'h0, '0, '0, '0));
        send_request(make_request(OP_BIND_SHADER, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(OP_INV_SHADER, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(OP_BIND_SHADER, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(OP_INV_SHADER, 32'h5, '0, '0, '0));
        send_request(make_request(OP_BIND_SHADER, 32'hFFFF_FFFF, '0, '0, '0));
    endtask

    task automatic test_texture_binds();
        send_request(make_request(OP_BIND_TEXTURE, '0, TARGET_TEXTURE_2D, 32'h0, 8'd0));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'hFFFF, 32'h0, 8'd0));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'hFFFF, 32'h0, 8'd0));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'hFFFF, 32'hFFFF_FFFF, 8'd0));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'h0, 32'h7, 8'd31));
        send_request(make_request(OP_BIND_TEXTURE, '0, TARGET_TEXTURE_2D, 32'h7, 8'd32));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'hFFFF, 32'hFFFF_FFFF, 8'd255));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'h0, 32'h7, 8'd31));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'h0, 32'h9, 8'd31));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'h0, 32'h9, 8'd1));
        send_request(make_request(OP_INV_TEXTURE, '0, '0, 32'h9, '0));
        send_request(make_request(OP_INV_TEXTURE, '0, '0, 32'h0, '0));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'h0, 32'h9, 8'd1));
        send_request(make_request(OP_RESET, '0, '0, '0, '0));
        send_request(make_request(OP_BIND_TEXTURE, '0, 16'hFFFF, 32'hFFFF_FFFF, 8'd0));
        send_request(make_request(OP_SPARE_FIRST, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 8'd3));
        send_request(make_request(OP_SPARE_LAST, 32'h0, 16'hFFFF, 32'hFFFF_FFFF, 8'd255));
        idle_cycles(1);
    endtask

    task automatic test_random_with_gaps(input int n_items);
        t_request req;
        int       useful;
        bit       gaps_on;
        useful = 0;
        while (useful < n_items) begin
            if (useful % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            req = random_request();
            send_request(req);
            if (req.opcode <= OP_RESET)
                useful++;
            if (gaps_on && $urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 9));
        end
    endtask

    // the sender holds off until every predicted word has come out
    task automatic test_drain_pause(input int n_groups);
        t_request req;
        for (int g = 0; g < n_groups; g++) begin
            for (int k = 0; k < 10; k++) begin
                req = random_request();
                send_request(req);
            end
            wait_for_drain();
        end
    endtask

    task automatic test_random_back_to_back(input int n_items);
        t_request req;
        int       useful;
        useful = 0;
        while (useful < n_items) begin
            req = random_request();
            send_request(req);
            if (req.opcode <= OP_RESET)
                useful++;
        end
    endtask

    always @(posedge i_clk) begin : word_check
        t_command want;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d value %h target %h last %b",
                    o_command_kind, o_command_value, o_command_target, o_last));
            end else begin
                want = expected_words.pop_front();
                if (o_command_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                        o_command_kind, want.kind));
                if (o_command_value !== want.value)
                    report_mismatch($sformatf("value %h, expected %h",
                        o_command_value, want.value));
                if (o_command_target !== want.target)
                    report_mismatch($sformatf("target %h, expected %h",
                        o_command_target, want.target));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                words_checked++;
            end
        end
    end

    initial begin
        int guard;
        clear_shadow_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_shader_binds();
        test_texture_binds();
        test_random_with_gaps(850);
        test_drain_pause(10);
        test_random_back_to_back(300);

        start <= 1'b0;
        guard = 0;
        while (expected_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                expected_words.size()));

        $display("run covered %0d requests (%0d with spare opcodes) and %0d command words",
            requests_sent, spare_sent, words_checked);
        $display("mix of shader and texture binds, invalidates, resets, gaps and drain pauses");
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for the filter");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
